>>> hw/rtl/crc_checked_frame_deframer_unit_macros.svh
// assertion helpers for the deframer
`ifndef CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// next-cycle implication, checked out of reset
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define CFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/cfd_pkg.sv
package cfd_pkg;

    localparam logic [7:0]  SOF_BYTE   = 8'hA5;
    localparam logic [7:0]  CRC8_INIT  = 8'hFF;
    localparam logic [7:0]  CRC8_POLY  = 8'h8C;
    localparam logic [15:0] CRC16_INIT = 16'hFFFF;
    localparam logic [15:0] CRC16_POLY = 16'h8408;

    localparam logic [15:0] CMD_LOW_RESET  = 16'h0A01;
    localparam logic [15:0] CMD_HIGH_RESET = 16'h0A05;

    localparam logic CFG_IDX_LOW  = 1'b0;
    localparam logic CFG_IDX_HIGH = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_PASS      = 2'd1;
    localparam logic [1:0] KIND_HDR_FAIL  = 2'd2;
    localparam logic [1:0] KIND_FRM_FAIL  = 2'd3;

    typedef struct packed {
        logic [7:0]  hcrc;
        logic [15:0] fcrc;
    } t_crc;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] command_id;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [7:0]  sequence_res;
        logic        accepted;
        logic        last;
    } t_result;

    // reflected crc8, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // reflected crc16, one byte
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/cfd_crc.sv
module cfd_crc
    import cfd_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic       i_restart,
    input  t_crc       i_crc,
    output t_crc       o_crc
);

    t_crc base;

    // a start byte seeds both checksums from their initial values
    always_comb begin
        base.hcrc = i_restart ? CRC8_INIT  : i_crc.hcrc;
        base.fcrc = i_restart ? CRC16_INIT : i_crc.fcrc;
    end

    assign o_crc.hcrc = crc8_step(base.hcrc, i_byte);
    assign o_crc.fcrc = crc16_step(base.fcrc, i_byte);

endmodule

>>> hw/rtl/crc_checked_frame_deframer_unit.sv
// channel   direction  handshake           payload
// rx        in         i_valid / o_stall   i_rx_byte
// result    out        o_valid / i_stall   o_kind .. o_last
// config    in         i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the result side does not stall; a byte waits in the input
// register and its result, if any, is registered in the output register.
// the frame state and both crc updates sit between these two registers.
// i_rst_n is synchronous and active low; it returns the parser to hunting.
// a held result under i_stall holds the input register, which then raises o_stall.
`include "crc_checked_frame_deframer_unit_macros.svh"

module crc_checked_frame_deframer_unit
    import cfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_command_id,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [15:0] o_frame_length,
    output logic [7:0]  o_sequence_res,
    output logic        o_accepted,
    output logic        o_last
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_SEQ,
        PH_HCRC,
        PH_CMD_LO,
        PH_CMD_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    logic [15:0] r_cfg_low;
    logic [15:0] r_cfg_high;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    t_phase      r_phase,  n_phase;
    logic [15:0] r_len,    n_len;
    logic [7:0]  r_seq,    n_seq;
    logic [15:0] r_cmd,    n_cmd;
    logic [15:0] r_count,  n_count;
    t_crc        r_crc,    n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic        r_out_valid;
    t_result     r_out;

    logic        out_free;
    logic        work;
    logic        in_range;
    logic        res_valid;
    t_result     res;
    t_crc        crc_next;

    assign out_free = !r_out_valid || !i_stall;
    assign work     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_range = (r_cmd >= r_cfg_low) && (r_cmd <= r_cfg_high);

    cfd_crc u_crc (
        .i_byte    (r_in_byte),
        .i_restart (r_phase == PH_HUNT),
        .i_crc     (r_crc),
        .o_crc     (crc_next)
    );

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_seq     = r_seq;
        n_cmd     = r_cmd;
        n_count   = r_count;
        n_crc     = r_crc;
        n_crc_lo  = r_crc_lo;
        res_valid = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.command_id   = r_cmd;
        res.payload_byte = 8'h00;
        res.byte_index   = 16'h0000;
        res.frame_length = r_len;
        res.sequence_res = r_seq;
        res.accepted     = in_range;
        res.last         = 1'b0;
        if (work) begin
            case (r_phase)
                PH_LEN_LO: begin
                    n_len   = {8'h00, r_in_byte};
                    n_crc   = crc_next;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len   = {r_in_byte, r_len[7:0]};
                    n_crc   = crc_next;
                    n_phase = PH_SEQ;
                end
                PH_SEQ: begin
                    n_seq   = r_in_byte;
                    n_crc   = crc_next;
                    n_phase = PH_HCRC;
                end
                PH_HCRC: begin
                    if (r_in_byte != r_crc.hcrc) begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_HDR_FAIL;
                        res.command_id = 16'h0000;
                        res.accepted   = 1'b0;
                        res.last       = 1'b1;
                        n_phase        = PH_HUNT;
                    end else begin
                        n_crc.fcrc = crc_next.fcrc;
                        n_phase    = PH_CMD_LO;
                    end
                end
                PH_CMD_LO: begin
                    n_cmd      = {8'h00, r_in_byte};
                    n_crc.fcrc = crc_next.fcrc;
                    n_phase    = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    n_cmd      = {r_in_byte, r_cmd[7:0]};
                    n_crc.fcrc = crc_next.fcrc;
                    n_count    = 16'h0000;
                    n_phase    = (r_len == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_crc.fcrc = crc_next.fcrc;
                    n_count    = r_count + 16'd1;
                    if (n_count == r_len) begin
                        n_phase = PH_CRC_LO;
                    end
                    // out-of-range commands drop their payload silently
                    res_valid        = in_range;
                    res.payload_byte = r_in_byte;
                    res.byte_index   = r_count;
                end
                PH_CRC_LO: begin
                    n_crc_lo = r_in_byte;
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    res_valid = 1'b1;
                    res.kind  = ({r_in_byte, r_crc_lo} == r_crc.fcrc) ? KIND_PASS
                                                                       : KIND_FRM_FAIL;
                    res.last  = 1'b1;
                    n_phase   = PH_HUNT;
                end
                default: begin
                    // hunting, and any code outside the frame phases
                    n_phase = PH_HUNT;
                    if (r_in_byte == SOF_BYTE) begin
                        n_crc    = crc_next;
                        n_len    = 16'h0000;
                        n_seq    = 8'h00;
                        n_cmd    = 16'h0000;
                        n_count  = 16'h0000;
                        n_crc_lo = 8'h00;
                        n_phase  = PH_LEN_LO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_low   <= CMD_LOW_RESET;
            r_cfg_high  <= CMD_HIGH_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_len       <= 16'h0000;
            r_seq       <= 8'h00;
            r_cmd       <= 16'h0000;
            r_count     <= 16'h0000;
            r_crc.hcrc  <= CRC8_INIT;
            r_crc.fcrc  <= CRC16_INIT;
            r_crc_lo    <= 8'h00;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_IDX_LOW:  r_cfg_low  <= i_cfg_data;
                    CFG_IDX_HIGH: r_cfg_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= res_valid;
            end
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_seq    <= n_seq;
            r_cmd    <= n_cmd;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (work && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_command_id   = r_out.command_id;
    assign o_payload_byte = r_out.payload_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_length = r_out.frame_length;
    assign o_sequence_res = r_out.sequence_res;
    assign o_accepted     = r_out.accepted;
    assign o_last         = r_out.last;

    `CFD_ASSERT_NOW(a_last_is_verdict, i_clk, i_rst_n,
        o_valid, (o_last == 1'b1) == (o_kind != KIND_PAYLOAD))
    `CFD_ASSERT_NOW(a_hdr_fail_clean, i_clk, i_rst_n,
        o_valid && (o_kind == KIND_HDR_FAIL), (o_command_id == 16'h0000) && !o_accepted)
    `CFD_ASSERT_NOW(a_index_in_frame, i_clk, i_rst_n,
        o_valid && (o_kind == KIND_PAYLOAD), o_byte_index < o_frame_length)
    `CFD_ASSERT_NEXT(a_held_byte_kept, i_clk, i_rst_n,
        r_in_valid && !out_free, r_in_valid && $stable(r_in_byte) && $stable(r_phase))

endmodule

>>> verif/crc_checked_frame_deframer_unit_tb.sv
`timescale 1ns / 100ps

module crc_checked_frame_deframer_unit_tb;
    import cfd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 115;

    typedef enum logic [3:0] {
        PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_SEQ, PH_HCRC,
        PH_CMD_LO, PH_CMD_HI, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
    } parse_phase_e;

    typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_BODY, FLAW_CUT} frame_flaw_e;

    // tracks the frame parser and holds the outputs it still owes
    class frame_tracker;
        logic [15:0]  cmd_low;
        logic [15:0]  cmd_high;
        parse_phase_e phase;
        logic [15:0]  ann_len;
        logic [7:0]   seq;
        logic [15:0]  cmd;
        logic [15:0]  count;
        logic [7:0]   hcrc;
        logic [15:0]  fcrc;
        logic [7:0]   crc_lo;
        t_result      pending_out[$];
        int           errors;

        function new();
            cmd_low  = CMD_LOW_RESET;
            cmd_high = CMD_HIGH_RESET;
            phase    = PH_HUNT;
            ann_len  = '0;
            seq      = '0;
            cmd      = '0;
            count    = '0;
            hcrc     = CRC8_INIT;
            fcrc     = CRC16_INIT;
            crc_lo   = '0;
            errors   = 0;
        endfunction

        // bit-serial, lsb first
        static function logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] d);
            logic [7:0] c;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                if (c[0] ^ d[i]) c = (c >> 1) ^ CRC8_POLY;
                else c = c >> 1;
            end
            return c;
        endfunction

        static function logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] d);
            logic [15:0] c;
            c = crc;
            for (int i = 0; i < 8; i++) begin
                if (c[0] ^ d[i]) c = (c >> 1) ^ CRC16_POLY;
                else c = c >> 1;
            end
            return c;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_IDX_LOW) cmd_low = val;
            else cmd_high = val;
        endfunction

        function bit cmd_in_range();
            return cmd >= cmd_low && cmd <= cmd_high;
        endfunction

        function void push_out(logic [1:0] kind, logic [15:0] cid, logic [7:0] pb,
                               logic [15:0] idx, logic acc, logic lst);
            t_result r;
            r.kind         = kind;
            r.command_id   = cid;
            r.payload_byte = pb;
            r.byte_index   = idx;
            r.frame_length = ann_len;
            r.sequence_res = seq;
            r.accepted     = acc;
            r.last         = lst;
            pending_out.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [15:0] idx;
            case (phase)
                PH_LEN_LO: begin
                    ann_len = {8'h00, b};
                    hcrc    = crc8_next(hcrc, b);
                    fcrc    = crc16_next(fcrc, b);
                    phase   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    ann_len[15:8] = b;
                    hcrc  = crc8_next(hcrc, b);
                    fcrc  = crc16_next(fcrc, b);
                    phase = PH_SEQ;
                end
                PH_SEQ: begin
                    seq   = b;
                    hcrc  = crc8_next(hcrc, b);
                    fcrc  = crc16_next(fcrc, b);
                    phase = PH_HCRC;
                end
                PH_HCRC: begin
                    if (b != hcrc) begin
                        push_out(KIND_HDR_FAIL, '0, '0, '0, 1'b0, 1'b1);
                        phase = PH_HUNT;
                    end else begin
                        fcrc  = crc16_next(fcrc, b);
                        phase = PH_CMD_LO;
                    end
                end
                PH_CMD_LO: begin
                    cmd   = {8'h00, b};
                    fcrc  = crc16_next(fcrc, b);
                    phase = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    cmd[15:8] = b;
                    fcrc  = crc16_next(fcrc, b);
                    count = '0;
                    phase = (ann_len == 0) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    idx   = count;
                    fcrc  = crc16_next(fcrc, b);
                    count = count + 16'd1;
                    if (count == ann_len) phase = PH_CRC_LO;
                    if (cmd_in_range()) push_out(KIND_PAYLOAD, cmd, b, idx, 1'b1, 1'b0);
                end
                PH_CRC_LO: begin
                    crc_lo = b;
                    phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    push_out(({b, crc_lo} == fcrc) ? KIND_PASS : KIND_FRM_FAIL,
                             cmd, '0, '0, cmd_in_range(), 1'b1);
                    phase = PH_HUNT;
                end
                default: begin
                    phase = PH_HUNT;
                    if (b == SOF_BYTE) begin
                        hcrc    = crc8_next(CRC8_INIT, b);
                        fcrc    = crc16_next(CRC16_INIT, b);
                        ann_len = '0;
                        seq     = '0;
                        cmd     = '0;
                        count   = '0;
                        crc_lo  = '0;
                        phase   = PH_LEN_LO;
                    end
                end
            endcase
        endfunction

        function void diff(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_out(t_result got);
            t_result want;
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected item, kind %0d command %0h", $time,
                         got.kind, got.command_id);
                errors++;
                return;
            end
            want = pending_out.pop_front();
            diff("kind", want.kind, got.kind);
            diff("command_id", want.command_id, got.command_id);
            diff("payload_byte", want.payload_byte, got.payload_byte);
            diff("byte_index", want.byte_index, got.byte_index);
            diff("frame_length", want.frame_length, got.frame_length);
            diff("sequence_res", want.sequence_res, got.sequence_res);
            diff("accepted", want.accepted, got.accepted);
            diff("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [15:0] o_command_id;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_byte_index;
    logic [15:0] o_frame_length;
    logic [7:0]  o_sequence_res;
    logic        o_accepted;
    logic        o_last;

    frame_tracker tracker = new();
    int  burst_left = 0;
    int  bytes_sent = 0;
    bit  hold_req   = 1'b0;

    crc_checked_frame_deframer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_command_id   (o_command_id),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_sequence_res (o_sequence_res),
        .o_accepted     (o_accepted),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // offers one byte, with a random gap between bursts
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        tracker.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [15:0] len, input logic [7:0] seq,
                              input logic [15:0] cmd, input frame_flaw_e flaw);
        logic [7:0]  fb[$];
        logic [7:0]  h;
        logic [15:0] f;
        int          cut;
        int          pos;
        fb = {SOF_BYTE, len[7:0], len[15:8], seq};
        h = CRC8_INIT;
        foreach (fb[i]) h = frame_tracker::crc8_next(h, fb[i]);
        fb.push_back(h);
        fb.push_back(cmd[7:0]);
        fb.push_back(cmd[15:8]);
        repeat (len) fb.push_back(8'($urandom_range(0, 255)));
        f = CRC16_INIT;
        foreach (fb[i]) f = frame_tracker::crc16_next(f, fb[i]);
        fb.push_back(f[7:0]);
        fb.push_back(f[15:8]);
        cut = fb.size();
        case (flaw)
            FLAW_HEADER: begin
                fb[4] = fb[4] ^ 8'($urandom_range(1, 255));
                cut = 5;
            end
            FLAW_BODY: begin
                pos = $urandom_range(5, fb.size() - 1);
                fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
            end
            FLAW_CUT: cut = $urandom_range(1, fb.size() - 1);
            default: ;
        endcase
        for (int i = 0; i < cut; i++) send_byte(fb[i]);
    endtask

    // stop offering and wait until every owed item has come out
    task automatic settle();
        i_valid <= 1'b0;
        while (tracker.pending_out.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_range(input logic [15:0] low, input logic [15:0] high);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_LOW;
        i_cfg_data  <= low;
        @(posedge i_clk);
        tracker.set_reg(CFG_IDX_LOW, low);
        i_cfg_index <= CFG_IDX_HIGH;
        i_cfg_data  <= high;
        @(posedge i_clk);
        tracker.set_reg(CFG_IDX_HIGH, high);
        i_cfg_wr_en <= 1'b0;
    endtask

    // commands at and just past the edges of the window, plus some inside it and some anywhere
    function automatic logic [15:0] pick_cmd();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = tracker.cmd_low;
        hi = tracker.cmd_high;
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return lo - 16'd1;
            3: return hi + 16'd1;
            4: return (lo <= hi) ? lo + 16'($urandom_range(0, hi - lo))
                                 : 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_traffic(input int nbytes);
        int          start;
        int          pick;
        logic [15:0] len;
        start = bytes_sent;
        while (bytes_sent - start < nbytes) begin
            pick = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 150))
                                               : 16'($urandom_range(0, 12));
            if (pick < 90) begin
                // header failures use any length, so every bit of it shows up
                if (pick >= 72 && pick < 82) len = 16'($urandom_range(0, 65535));
                send_frame(len, 8'($urandom_range(0, 255)), pick_cmd(),
                           (pick < 60) ? FLAW_NONE :
                           (pick < 72) ? FLAW_BODY :
                           (pick < 82) ? FLAW_HEADER : FLAW_CUT);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin : result_side
        t_result got;
        int      mode;
        int      mode_left;
        int      hold_left;
        i_stall   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.kind         = o_kind;
                got.command_id   = o_command_id;
                got.payload_byte = o_payload_byte;
                got.byte_index   = o_byte_index;
                got.frame_length = o_frame_length;
                got.sequence_res = o_sequence_res;
                got.accepted     = o_accepted;
                got.last         = o_last;
                tracker.check_out(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 2) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge i_rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("crc_checked_frame_deframer_unit_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_IDX_LOW;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_rx_byte   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray bytes, empty payload pass, header failure, bad frame crc
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(16'd0, 8'h00, CMD_LOW_RESET, FLAW_NONE);
        send_frame(16'hFFFF, 8'hFF, 16'hFFFF, FLAW_HEADER);
        send_frame(16'd1, 8'h80, CMD_HIGH_RESET, FLAW_BODY);
        random_traffic(PHASE_BYTES / 2);

        for (int p = 0; p < 6; p++) begin
            settle();
            case (p)
                0: program_range(16'h0000, 16'hFFFF);
                1: program_range(16'hFFFF, 16'hFFFF);
                2: program_range(16'h0100, 16'h00FF);  // empty window
                3: program_range(16'h0000, 16'h0000);
                4: program_range(16'($urandom_range(0, 32767)),
                                 16'($urandom_range(32768, 65535)));
                default: program_range(16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)));
            endcase
            if (p == 1) hold_req = 1'b1;  // receiver backs off while bytes keep coming
            random_traffic(PHASE_BYTES / 2);
            if (p == 3) settle();
            random_traffic(PHASE_BYTES / 2);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending_out.size() == 0) begin
            $display("crc_checked_frame_deframer_unit_tb OK");
        end else begin
            $display("crc_checked_frame_deframer_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_crc.sv
hw/rtl/crc_checked_frame_deframer_unit.sv
verif/crc_checked_frame_deframer_unit_tb.sv
